// ----- design/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// sed_pkg
// Shared widths, sizes, register codes and pipeline control types for the
// squared Euclidean distance block.
// ----------------------------------------------------------------------------
package sed_pkg;

  // Sizes of the query store and the row counter.
  localparam int MAX_DIM  = 256;
  localparam int MAX_ROWS = 65536;

  // Field widths.
  localparam int VAL_W  = 16;
  localparam int NORM_W = 39;
  localparam int ACC_W  = 40;
  localparam int DIST_W = 42;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ROW_W  = 16;
  localparam int CFG_W  = 32;
  localparam int FIRST_W = 16;
  localparam int END_W   = 17;

  // The element index counts 0..MAX_DIM; the store address covers 0..MAX_DIM-1.
  localparam int IDX_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // The row counter wraps at MAX_ROWS or at the 16-bit limit, whichever is first.
  localparam int ROW_WRAP = (MAX_ROWS < 65536) ? MAX_ROWS : 65536;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_WRAP - 1);

  // Configuration bus.
  localparam int APB_AW = 3;
  localparam logic [END_W-1:0] END_ROW_RESET = END_W'(65536);

  // Register indexes on the configuration bus.
  typedef enum logic [0:0] {
    REG_FIRST_ROW = 1'b0,
    REG_END_ROW   = 1'b1
  } sed_reg_t;

  // Item modes.
  typedef enum logic [0:0] {
    MODE_QUERY = 1'b0,
    MODE_ROW   = 1'b1
  } sed_mode_t;

  // Control that travels with an item through the multiply and accumulate stages.
  typedef struct packed {
    logic      valid;
    sed_mode_t mode;
    logic      last;   // final element of the vector
    logic      acc;    // element lies inside the store, so it is accumulated
    logic      clr;    // first element: the accumulator starts from zero
    logic      emit;   // row number lies in the selected range
    logic      err;    // length error including this element
  } sed_ctrl_t;

endpackage

// ----- design/sed_if.sv -----
// ----------------------------------------------------------------------------
// sed_if
// Valid/ready channels of the squared Euclidean distance block: the input
// element channel and the distance result channel.
// ----------------------------------------------------------------------------

// Input element channel.
interface sed_item_if import sed_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [VAL_W-1:0] value;
  logic [NORM_W-1:0]       row_norm;
  logic                    last_element;

  modport source (output valid, mode, value, row_norm, last_element, input ready);
  modport sink   (input valid, mode, value, row_norm, last_element, output ready);
endinterface

// Distance result channel.
interface sed_result_if import sed_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] distance;
  logic [ROW_W-1:0]         row_number;
  logic                     length_error;

  modport source (output valid, distance, row_number, length_error, input ready);
  modport sink   (input valid, distance, row_number, length_error, output ready);
endinterface

// ----- design/squared_euclid_distance.sv -----
// ----------------------------------------------------------------------------
// squared_euclid_distance
// Squared distance from a stored query vector to streamed data rows, computed
// as row_norm + q.q - 2 * (row . q).
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one beat per vector element. Mode 0 beats load the query
//   into the query store and sum its squared norm; mode 1 beats stream a data
//   row, one element per beat, and last_element marks the final element of
//   the query or of a row. row_norm is sampled on a row's last beat.
//   result channel: one beat per finished row whose number lies in
//   [first_row, end_row), carrying the distance, the row number and a flag
//   for a query or row longer than MAX_DIM elements.
//   APB port: first_row at byte address 0, end_row at byte address 4.
// Throughput: one item per cycle unless the result channel stalls, set by the
//   single read port of the query store and the one multiply-accumulate unit.
//   A row's result goes through the stage 1, 2, 3 and output registers.
// Reset (synchronous): empties the pipeline, clears all counters and norms,
//   marks every query store entry as zero and restores the register defaults.
// Stall: while a result waits and the receiver holds ready low, the whole
//   pipeline holds and the item channel drops ready.
// ----------------------------------------------------------------------------
module squared_euclid_distance import sed_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  sed_item_if.sink          item,
  sed_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  // Configuration registers.
  logic [FIRST_W-1:0] first_row;
  logic [END_W-1:0]   end_row;
  sed_reg_t           reg_sel;
  logic               cfg_write;

  // Front-end state.
  logic [IDX_W-1:0]  elem_idx;
  logic [IDX_W-1:0]  elem_idx_next;
  logic [ROW_W-1:0]  row_cnt;
  logic [ROW_W-1:0]  row_cnt_next;
  logic              ovf_flag;
  logic              ovf_flag_next;

  // Query store and its entry valid bits.
  logic [VAL_W-1:0]   qmem [MAX_DIM];
  logic [MAX_DIM-1:0] qvalid;
  logic [VAL_W-1:0]   rd_data;
  logic               rd_vld;

  // Pipeline stages.
  logic                     advance;
  logic                     accept;
  logic                     in_range;
  logic                     row_end;
  logic [ADDR_W-1:0]        addr;
  sed_ctrl_t                s0_ctrl;
  sed_ctrl_t                p1_ctrl;
  logic signed [VAL_W-1:0]  p1_value;
  logic [NORM_W-1:0]        p1_rnorm;
  logic [ROW_W-1:0]         p1_row;
  logic signed [VAL_W-1:0]  q_elem;
  logic signed [VAL_W-1:0]  mul_b;
  sed_ctrl_t                p2_ctrl;
  logic signed [PROD_W-1:0] p2_prod;
  logic [NORM_W-1:0]        p2_rnorm;
  logic [ROW_W-1:0]         p2_row;
  logic [NORM_W-1:0]        qnorm;
  logic [NORM_W-1:0]        qnorm_sum;
  logic [ACC_W-1:0]         dot;
  logic [ACC_W-1:0]         dot_sum;
  logic                     p3_valid;
  logic [NORM_W-1:0]        p3_rnorm;
  logic [NORM_W-1:0]        p3_qnorm;
  logic [ACC_W-1:0]         p3_dot;
  logic [ROW_W-1:0]         p3_row;
  logic                     p3_err;
  logic signed [DIST_W-1:0] dist_calc;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = sed_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_row <= '0;
      end_row   <= END_ROW_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FIRST_ROW: first_row <= pwdata[FIRST_W-1:0];
        REG_END_ROW:   end_row   <= pwdata[END_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_ROW: prdata = {{(CFG_W-FIRST_W){1'b0}}, first_row};
      REG_END_ROW:   prdata = {{(CFG_W-END_W){1'b0}}, end_row};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the pipeline moves whenever the output register can take a beat.
  // --------------------------------------------------------------------------
  assign advance    = !result.valid || result.ready;
  assign item.ready = advance;
  assign accept     = item.valid && advance;

  // --------------------------------------------------------------------------
  // Stage 0: element position, length check, row bookkeeping.
  // --------------------------------------------------------------------------
  assign in_range = (elem_idx < IDX_W'(MAX_DIM));
  assign addr     = elem_idx[ADDR_W-1:0];
  assign row_end  = (sed_mode_t'(item.mode) == MODE_ROW) && item.last_element;

  always_comb begin
    elem_idx_next = elem_idx;
    ovf_flag_next = ovf_flag;
    row_cnt_next  = row_cnt;
    if (accept) begin
      if (in_range) begin
        elem_idx_next = elem_idx + IDX_W'(1);
      end else begin
        ovf_flag_next = 1'b1;
      end
      if (item.last_element) begin
        elem_idx_next = '0;
      end
      // A finished row clears the flag and moves on to the next row number.
      if (row_end) begin
        ovf_flag_next = 1'b0;
        row_cnt_next  = (row_cnt == ROW_LAST) ? '0 : row_cnt + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_idx <= '0;
      ovf_flag <= 1'b0;
      row_cnt  <= '0;
    end else begin
      elem_idx <= elem_idx_next;
      ovf_flag <= ovf_flag_next;
      row_cnt  <= row_cnt_next;
    end
  end

  // Control word for the item entering the pipeline.
  always_comb begin
    s0_ctrl.valid = accept;
    s0_ctrl.mode  = sed_mode_t'(item.mode);
    s0_ctrl.last  = item.last_element;
    s0_ctrl.acc   = in_range;
    s0_ctrl.clr   = (elem_idx == '0);
    s0_ctrl.emit  = (row_cnt >= first_row) && ({1'b0, row_cnt} < end_row);
    s0_ctrl.err   = ovf_flag || !in_range;
  end

  // --------------------------------------------------------------------------
  // Query store: query beats write, row beats read the element at the same
  // position. Entries never written read as zero through their valid bits.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      if (s0_ctrl.mode == MODE_QUERY && in_range) begin
        qmem[addr] <= item.value;
      end
      rd_data <= qmem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid <= '0;
      rd_vld <= 1'b0;
    end else if (accept) begin
      if (s0_ctrl.mode == MODE_QUERY && in_range) begin
        qvalid[addr] <= 1'b1;
      end
      rd_vld <= qvalid[addr];
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_ctrl <= '0;
    end else if (advance) begin
      p1_ctrl <= s0_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_value <= item.value;
      p1_rnorm <= item.row_norm;
      p1_row   <= row_cnt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: one multiplier, squaring query elements or forming row * query.
  // --------------------------------------------------------------------------
  assign q_elem = rd_vld ? $signed(rd_data) : '0;
  assign mul_b  = (p1_ctrl.mode == MODE_ROW) ? q_elem : p1_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_ctrl <= '0;
    end else if (advance) begin
      p2_ctrl <= p1_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_prod  <= p1_value * mul_b;
      p2_rnorm <= p1_rnorm;
      p2_row   <= p1_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: accumulate into the query norm or the dot product.
  // --------------------------------------------------------------------------
  always_comb begin
    qnorm_sum = p2_ctrl.clr ? '0 : qnorm;
    dot_sum   = p2_ctrl.clr ? '0 : dot;
    if (p2_ctrl.acc) begin
      qnorm_sum = qnorm_sum + {{(NORM_W-PROD_W){p2_prod[PROD_W-1]}}, p2_prod};
      dot_sum   = dot_sum + {{(ACC_W-PROD_W){p2_prod[PROD_W-1]}}, p2_prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qnorm <= '0;
      dot   <= '0;
    end else if (advance && p2_ctrl.valid) begin
      if (p2_ctrl.mode == MODE_QUERY) begin
        qnorm <= qnorm_sum;
      end else begin
        // The dot product starts over after each row.
        dot <= p2_ctrl.last ? '0 : dot_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (advance) begin
      p3_valid <= p2_ctrl.valid && (p2_ctrl.mode == MODE_ROW) && p2_ctrl.last
                  && p2_ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p3_rnorm <= p2_rnorm;
      p3_qnorm <= qnorm;
      p3_dot   <= dot_sum;
      p3_row   <= p2_row;
      p3_err   <= p2_ctrl.err;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: distance = row_norm + query_norm - 2 * dot, into the output register.
  // --------------------------------------------------------------------------
  assign dist_calc = $signed({{(DIST_W-NORM_W){1'b0}}, p3_rnorm})
                   + $signed({{(DIST_W-NORM_W){1'b0}}, p3_qnorm})
                   - $signed({p3_dot[ACC_W-1], p3_dot, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.distance     <= dist_calc;
      result.row_number   <= p3_row;
      result.length_error <= p3_err;
    end
  end

endmodule

// ----- verif/squared_euclid_distance_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// squared_euclid_distance_tb
// Self-checking bench for the squared Euclidean distance block. Query and row
// beats are driven from a queue with random gaps. Every accepted beat runs
// through a predictor of the block, and the result channel is checked
// against the predicted distances in order. The row range is reprogrammed
// over APB between phases and read back each time.
// ----------------------------------------------------------------------------
module squared_euclid_distance_tb;
  import sed_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // One element beat as queued for the driver.
  typedef struct packed {
    sed_mode_t               mode;
    logic signed [VAL_W-1:0] value;
    logic [NORM_W-1:0]       row_norm;
    logic                    last;
  } elem_t;

  // One distance beat as predicted.
  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic [ROW_W-1:0]         row_number;
    logic                     length_error;
  } dist_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;

  sed_item_if   item_ch ();
  sed_result_if res_ch ();

  squared_euclid_distance dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and expectation stores.
  elem_t pending_elems[$];
  dist_t expected_dists[$];
  int    fault_cnt = 0;
  int    cycle_cnt = 0;
  bit    item_took = 1'b0;
  bit    calm = 1'b0;
  int    q_len = 1;

  // Predictor state and its copy of the row range.
  logic signed [VAL_W-1:0] q_store [MAX_DIM] = '{default: '0};
  logic [NORM_W-1:0]       q_norm = '0;
  logic signed [ACC_W-1:0] dot_acc = '0;
  int                      vec_idx = 0;
  logic [ROW_W-1:0]        row_cnt = '0;
  logic                    len_flag = 1'b0;
  logic [FIRST_W-1:0]      sel_first = '0;
  logic [END_W-1:0]        sel_end = END_ROW_RESET;

  always begin
    #2;
    clk = 1'b1;
    #2;
    clk = 1'b0;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Advances the predicted state by one accepted beat; returns 1 when the
  // beat finishes a row inside the selected range.
  function automatic bit predict_distance(input elem_t e, output dist_t d);
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  term;
    logic signed [DIST_W-1:0] twice_dot;
    bit fits;
    bit hit;
    fits = (vec_idx < MAX_DIM);
    hit = 1'b0;
    d = '0;
    if (e.mode == MODE_QUERY) begin
      if (vec_idx == 0) begin
        q_norm = '0;
      end
      if (fits) begin
        q_store[vec_idx] = e.value;
        prod = e.value * e.value;
        term = prod;
        q_norm = q_norm + NORM_W'(term);
        vec_idx++;
      end else begin
        len_flag = 1'b1;
      end
      if (e.last) begin
        vec_idx = 0;
      end
      return 1'b0;
    end
    if (vec_idx == 0) begin
      dot_acc = '0;
    end
    if (fits) begin
      prod = e.value * q_store[vec_idx];
      term = prod;
      dot_acc = dot_acc + term;
      vec_idx++;
    end else begin
      len_flag = 1'b1;
    end
    if (!e.last) begin
      return 1'b0;
    end
    twice_dot = dot_acc;
    twice_dot = twice_dot <<< 1;
    if (row_cnt >= sel_first && row_cnt < sel_end) begin
      d.distance = DIST_W'(e.row_norm) + DIST_W'(q_norm) - twice_dot;
      d.row_number = row_cnt;
      d.length_error = len_flag;
      hit = 1'b1;
    end
    vec_idx = 0;
    dot_acc = '0;
    len_flag = 1'b0;
    row_cnt = (row_cnt == ROW_LAST) ? '0 : row_cnt + 1'b1;
    return hit;
  endfunction

  // Predict on every accepted element beat.
  always @(posedge clk) begin : predict_on_accept
    elem_t e;
    dist_t d;
    item_took <= !rst && item_ch.valid && item_ch.ready;
    if (!rst && item_ch.valid && item_ch.ready) begin
      e.mode = sed_mode_t'(item_ch.mode);
      e.value = item_ch.value;
      e.row_norm = item_ch.row_norm;
      e.last = item_ch.last_element;
      if (predict_distance(e, d)) begin
        expected_dists.push_back(d);
      end
    end
  end

  // Element driver: holds a beat until it is taken, idles at random.
  always @(negedge clk) begin : drive_elems
    elem_t e;
    bit idle;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_took) begin
      idle = !calm && ($urandom_range(0, 99) < 13);
      if (!idle && pending_elems.size() != 0) begin
        e = pending_elems.pop_front();
        item_ch.valid <= 1'b1;
        item_ch.mode <= e.mode;
        item_ch.value <= e.value;
        item_ch.row_norm <= e.row_norm;
        item_ch.last_element <= e.last;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Result backpressure.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // Compare each result beat with the oldest predicted distance.
  always @(posedge clk) begin : check_dists
    dist_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_dists.size() == 0) begin
        $display("%0t: unexpected result beat: distance %0d row %0d error %0b", $time,
                 res_ch.distance, res_ch.row_number, res_ch.length_error);
        fault_cnt++;
      end else begin
        want = expected_dists.pop_front();
        if (res_ch.distance !== want.distance) begin
          $display("%0t: distance expected %0d got %0d", $time, want.distance,
                   res_ch.distance);
          fault_cnt++;
        end
        if (res_ch.row_number !== want.row_number) begin
          $display("%0t: row_number expected %0d got %0d", $time, want.row_number,
                   res_ch.row_number);
          fault_cnt++;
        end
        if (res_ch.length_error !== want.length_error) begin
          $display("%0t: length_error expected %0b got %0b", $time, want.length_error,
                   res_ch.length_error);
          fault_cnt++;
        end
      end
    end
  end

  function automatic logic [APB_AW-1:0] reg_addr(input sed_reg_t r);
    return APB_AW'(r) << 2;
  endfunction

  // APB read of one register, checked against the expected value.
  task automatic cfg_check(input sed_reg_t r, input logic [CFG_W-1:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= reg_addr(r);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %s read expected %0d got %0d", $time, r.name(), want, prdata);
      fault_cnt++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // APB write, mirrored into the predictor, then read back.
  task automatic cfg_write(input sed_reg_t r, input logic [CFG_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= reg_addr(r);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == REG_FIRST_ROW) begin
      sel_first = val[FIRST_W-1:0];
      cfg_check(r, CFG_W'(sel_first));
    end else begin
      sel_end = val[END_W-1:0];
      cfg_check(r, CFG_W'(sel_end));
    end
  endtask

  task automatic set_range(input int unsigned first, input int unsigned stop);
    cfg_write(REG_FIRST_ROW, CFG_W'(first));
    cfg_write(REG_END_ROW, CFG_W'(stop));
  endtask

  // Wait until every beat is sent and every distance has come back, then let
  // the pipeline empty of beats that produce nothing.
  task automatic drain();
    while (pending_elems.size() != 0 || item_ch.valid || expected_dists.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -16'sd1;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  function automatic logic [NORM_W-1:0] rand_norm();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return NORM_W'(64'd274877906944);
      default: return NORM_W'({$urandom(), $urandom()});
    endcase
  endfunction

  task automatic push_elem(input sed_mode_t m, input logic signed [VAL_W-1:0] v,
                           input logic [NORM_W-1:0] n, input bit last);
    elem_t e;
    e.mode = m;
    e.value = v;
    e.row_norm = n;
    e.last = last;
    pending_elems.push_back(e);
  endtask

  task automatic push_vector(input sed_mode_t m, input int len);
    for (int i = 0; i < len; i++) begin
      push_elem(m, rand_val(), rand_norm(), i == len - 1);
    end
  endtask

  // Random traffic: mostly whole queries and rows, some mode switches inside
  // a vector and some loose beats.
  task automatic random_traffic(input int budget);
    int sent;
    int pick;
    int n;
    sed_mode_t m;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        q_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        push_vector(MODE_QUERY, q_len);
        sent += q_len;
      end else if (pick < 80) begin
        n = ($urandom_range(0, 4) != 0) ? q_len : $urandom_range(1, 24);
        push_vector(MODE_ROW, n);
        sent += n;
      end else if (pick < 90) begin
        m = sed_mode_t'($urandom_range(0, 1));
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_elem(m, rand_val(), rand_norm(), 1'b0);
        sent += n;
        n = $urandom_range(1, 3);
        push_vector(sed_mode_t'(!m), n);
        sent += n;
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          push_elem(sed_mode_t'($urandom_range(0, 1)), rand_val(), rand_norm(),
                    $urandom_range(0, 1));
        end
        sent += n;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned first;
    item_ch.valid = 1'b0;
    item_ch.mode = 1'b0;
    item_ch.value = '0;
    item_ch.row_norm = '0;
    item_ch.last_element = 1'b0;
    res_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults after reset.
    cfg_check(REG_FIRST_ROW, '0);
    cfg_check(REG_END_ROW, CFG_W'(END_ROW_RESET));

    // Row before any query: the store still holds zeros.
    push_elem(MODE_ROW, 16'sd5, '0, 1'b0);
    push_elem(MODE_ROW, -16'sd7, '0, 1'b1);
    // Extreme query and row values with the largest norm.
    push_elem(MODE_QUERY, 16'sh7fff, '0, 1'b0);
    push_elem(MODE_QUERY, 16'sh8000, '0, 1'b0);
    push_elem(MODE_QUERY, 16'sd1, '0, 1'b1);
    push_elem(MODE_ROW, 16'sh8000, '0, 1'b0);
    push_elem(MODE_ROW, 16'sh7fff, '0, 1'b0);
    push_elem(MODE_ROW, -16'sd1, '1, 1'b1);
    push_elem(MODE_ROW, '0, NORM_W'(64'd274877906944), 1'b1);
    // Query left open, then row beats continue from the same position.
    push_elem(MODE_QUERY, 16'sd3, '0, 1'b0);
    push_elem(MODE_QUERY, 16'sd4, '0, 1'b0);
    push_elem(MODE_ROW, 16'sd2, '0, 1'b0);
    push_elem(MODE_ROW, 16'sd5, 39'd1000, 1'b1);
    // Short query, longer row reading older store entries.
    push_elem(MODE_QUERY, 16'sd100, '0, 1'b1);
    push_elem(MODE_ROW, 16'sd1, '0, 1'b0);
    push_elem(MODE_ROW, 16'sd2, '0, 1'b0);
    push_elem(MODE_ROW, 16'sd3, '0, 1'b0);
    push_elem(MODE_ROW, 16'sd4, 39'd77, 1'b1);
    // Row left open, then a query beat closes the vector.
    push_elem(MODE_ROW, 16'sd7, '0, 1'b0);
    push_elem(MODE_QUERY, 16'sd9, '0, 1'b1);
    push_elem(MODE_QUERY, 16'sh8000, '0, 1'b1);
    push_elem(MODE_ROW, 16'sh8000, '1, 1'b1);
    drain();

    // Full range.
    set_range(0, END_ROW_RESET);
    random_traffic(100);
    drain();

    // Narrow window just ahead of the current row.
    first = row_cnt + 2;
    set_range(first, first + 13);
    random_traffic(80);
    drain();

    // Empty range at the low end.
    set_range(0, 0);
    random_traffic(50);
    drain();

    // Only the top row number is selected.
    set_range(16'hffff, END_ROW_RESET);
    random_traffic(50);
    drain();

    // Full range with no gaps and no backpressure.
    set_range(0, END_ROW_RESET);
    calm = 1'b1;
    random_traffic(100);
    drain();
    calm = 1'b0;

    // Random window, possibly empty.
    first = $urandom_range(0, row_cnt + 40);
    set_range(first, first + $urandom_range(0, 40));
    random_traffic(120);
    drain();

    // Vectors at and past the store size.
    set_range(0, END_ROW_RESET);
    push_vector(MODE_QUERY, MAX_DIM + 1);
    push_vector(MODE_ROW, 3);
    push_vector(MODE_ROW, MAX_DIM + 1);
    push_vector(MODE_ROW, MAX_DIM);
    q_len = 4;
    push_vector(MODE_QUERY, q_len);
    random_traffic(60);
    drain();

    if (fault_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
